[rtl/sht_pkg.sv]
`timescale 1ns / 1ps

package sht_pkg;

  localparam int unsigned DEFAULT_ENTRIES = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned IP_W     = 32;
  localparam int unsigned TIME_W   = 17;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned COUNT_W  = 6;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 128;

  typedef enum logic [OP_W-1:0] {
    OP_OBSERVE = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_UPDATED  = 3'd0,
    STS_ADDED    = 3'd1,
    STS_FULL     = 3'd2,
    STS_READ_OK  = 3'd3,
    STS_READ_OOR = 3'd4,
    STS_CLEARED  = 3'd5
  } status_e;

  // one table entry as held in the entry ram
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [TIME_W-1:0] first_seen;
    logic [TIME_W-1:0] last_seen;
    logic              new_flag;
  } entry_t;

  // input tdata, last field in the lowest bits
  typedef struct packed {
    logic [1:0]        pad;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] seen_time;
    logic [IP_W-1:0]   station_ip;
    logic [MAC_W-1:0]  station_mac;
  } in_data_t;

  // output tdata, last field in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic               new_flag;
    logic [TIME_W-1:0]  last_seen_out;
    logic [TIME_W-1:0]  first_seen_out;
    logic [IP_W-1:0]    ip_out;
    logic [MAC_W-1:0]   mac_out;
    logic [COUNT_W-1:0] entry_count;
    logic [SLOT_W-1:0]  slot;
  } out_data_t;

endpackage

[rtl/sht_entry_ram.sv]
`timescale 1ns / 1ps

module sht_entry_ram import sht_pkg::*; #(
  parameter int unsigned DEPTH  = DEFAULT_ENTRIES,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  entry_t            wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/station_history_table_unit.sv]
`timescale 1ns / 1ps

// channel   | signals                              | transaction
// ----------+--------------------------------------+-------------------------------------
// s_axis    | tvalid tready tdata[103:0] tuser[1:0] | one command: observe, read or clear
// m_axis    | tvalid tready tdata[127:0] tuser[2:0] | one result per observe, read or clear
//
// observe: accept, then a scan over the entries compared (one ram read per cycle,
//   compares pipelined behind the read), then hand over; the scan is linear over the
//   stored entries, bound by the single read port of the entry ram
// read: accept, ram read, hand over; clear and out of range reads: accept, hand over
// an unused opcode is taken and gives no result
// reset clears the entry count and the control registers; ram contents stay undefined and are never read
//   before being written, since only entries below the count are read
// a new command is taken while the previous result still waits in the output register

module station_history_table_unit import sht_pkg::*; #(
  parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // station_mac, station_ip, seen_time, entry_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [OP_W-1:0]       s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot, entry_count, mac_out, ip_out, first_seen_out, last_seen_out, new_flag
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]   m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [ADDR_W-1:0]  ptr_q;
  logic [MAC_W-1:0]   mac_q;
  logic [IP_W-1:0]    ip_q;
  logic [TIME_W-1:0]  time_q;

  // finished result, waiting for the output register
  status_e            res_status_q;
  logic [SLOT_W-1:0]  res_slot_q;
  entry_t             res_entry_q;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  out_data_t          out_data_q;

  in_data_t           in_data;
  opcode_e            in_op;
  logic               in_acc;
  logic               hand_over;

  entry_t             rd_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;

  logic [MAC_W-1:0]   obs_mac;
  logic [IP_W-1:0]    obs_ip;
  logic [TIME_W-1:0]  obs_time;
  logic [CNT_W-1:0]   ptr_next;
  logic               hit;
  logic               more;
  logic               room;
  logic               empty;
  logic               idx_ok;
  entry_t             append_entry;
  entry_t             update_entry;

  assign in_data       = in_data_t'(s_axis_tdata);
  assign in_op         = opcode_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // finished result moves into the output register once it is free or being emptied
  assign hand_over = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // observed station comes straight from the port when an empty table is appended at once
  assign obs_mac  = (state_q == S_IDLE) ? in_data.station_mac : mac_q;
  assign obs_ip   = (state_q == S_IDLE) ? in_data.station_ip  : ip_q;
  assign obs_time = (state_q == S_IDLE) ? in_data.seen_time   : time_q;

  assign ptr_next = CNT_W'(ptr_q) + CNT_W'(1);
  assign hit      = (rd_data.mac == mac_q);
  assign more     = (ptr_next < count_q);
  assign room     = (count_q < CNT_W'(ENTRIES));
  assign empty    = (count_q == '0);
  // count never exceeds ENTRIES, so this also keeps the index inside the ram
  assign idx_ok   = (CMP_W'(in_data.entry_index) < CMP_W'(count_q));

  always_comb begin
    append_entry            = '0;
    append_entry.mac        = obs_mac;
    append_entry.ip         = obs_ip;
    append_entry.first_seen = obs_time;
    append_entry.last_seen  = obs_time;
    append_entry.new_flag   = 1'b1;

    update_entry            = rd_data;
    update_entry.ip         = ip_q;
    update_entry.last_seen  = time_q;
    update_entry.new_flag   = 1'b0;
  end

  // ram read and write-back; a write always ends an item, and the next item's first
  // read is issued no earlier than the cycle after, so no forwarding is needed
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ADDR_W'(count_q);
    wr_data = append_entry;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_op == OP_OBSERVE) begin
          rd_en = !empty;
          wr_en = empty;
        end else if (in_acc && in_op == OP_READ) begin
          rd_en   = idx_ok;
          rd_addr = ADDR_W'(in_data.entry_index);
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = ptr_q;
          wr_data = update_entry;
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(ptr_next);
        end else begin
          wr_en = room;
        end
      end
      default: ;
    endcase
  end

  sht_entry_ram #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      mac_q        <= '0;
      ip_q         <= '0;
      time_q       <= '0;
      res_status_q <= STS_CLEARED;
      res_slot_q   <= '0;
      res_entry_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STS_CLEARED;
      out_data_q   <= '0;
    end else begin
      if (m_axis_tready && !hand_over) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mac_q  <= in_data.station_mac;
            ip_q   <= in_data.station_ip;
            time_q <= in_data.seen_time;
            case (in_op)
              OP_OBSERVE: begin
                if (empty) begin
                  count_q      <= count_q + CNT_W'(1);
                  res_status_q <= STS_ADDED;
                  res_slot_q   <= '0;
                  res_entry_q  <= append_entry;
                  state_q      <= S_DONE;
                end else begin
                  ptr_q   <= '0;
                  state_q <= S_SCAN;
                end
              end
              OP_READ: begin
                res_slot_q <= in_data.entry_index;
                if (idx_ok) begin
                  state_q <= S_READ;
                end else begin
                  res_status_q <= STS_READ_OOR;
                  res_entry_q  <= '0;
                  state_q      <= S_DONE;
                end
              end
              OP_CLEAR: begin
                count_q      <= '0;
                res_status_q <= STS_CLEARED;
                res_slot_q   <= '0;
                res_entry_q  <= '0;
                state_q      <= S_DONE;
              end
              default: ;  // unused opcode: dropped without a result
            endcase
          end
        end
        S_SCAN: begin
          // rd_data holds the entry at ptr_q
          if (hit) begin
            res_status_q <= STS_UPDATED;
            res_slot_q   <= SLOT_W'(ptr_q);
            res_entry_q  <= update_entry;
            state_q      <= S_DONE;
          end else if (more) begin
            ptr_q <= ADDR_W'(ptr_next);
          end else if (room) begin
            count_q      <= count_q + CNT_W'(1);
            res_status_q <= STS_ADDED;
            res_slot_q   <= SLOT_W'(count_q);
            res_entry_q  <= append_entry;
            state_q      <= S_DONE;
          end else begin
            res_status_q <= STS_FULL;
            res_slot_q   <= '0;
            res_entry_q  <= '0;
            state_q      <= S_DONE;
          end
        end
        S_READ: begin
          res_status_q <= STS_READ_OK;
          res_entry_q  <= rd_data;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          // hand over once the output register is free or being emptied
          if (hand_over) begin
            out_valid_q               <= 1'b1;
            out_status_q              <= res_status_q;
            out_data_q.pad            <= '0;
            out_data_q.slot           <= res_slot_q;
            out_data_q.entry_count    <= COUNT_W'(count_q);
            out_data_q.mac_out        <= res_entry_q.mac;
            out_data_q.ip_out         <= res_entry_q.ip;
            out_data_q.first_seen_out <= res_entry_q.first_seen;
            out_data_q.last_seen_out  <= res_entry_q.last_seen;
            out_data_q.new_flag       <= res_entry_q.new_flag;
            state_q                   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = out_data_q;

  // table never holds more than ENTRIES stations
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  // the count only grows by one on an append or drops to zero on a clear
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q == '0))
    else $error("entry count changed by an illegal step");

  // the scan pointer stays among the valid entries
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(ptr_q) < count_q))
    else $error("scan pointer beyond valid entries");

  // a write-back always hands the item to the result stage
  a_write_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (state_q == S_DONE))
    else $error("ram written without finishing the item");

endmodule
